### src/peta_pkg.sv
package peta_pkg;

    localparam int PORT_W   = 12;
    localparam int PEER_W   = 16;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    // table depth: default and smallest supported value
    localparam int PORT_COUNT_DEF = 4096;
    localparam int PORT_COUNT_MIN = 16;

    // fixed-point shift of the reciprocal used to reduce a port to a table slot
    localparam int RECIP_SHIFT = 2 * PORT_W;

    localparam logic [PORT_W-1:0] PORT_FIRST_RST = PORT_W'(1);
    localparam logic [PORT_W-1:0] PORT_LAST_RST  = PORT_W'(4095);

    // request function codes
    localparam logic [FUNC_W-1:0] FN_ALLOC_EPH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC_FIX = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FREE      = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LOOKUP    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SET_RX    = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IN_USE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_LAST  = 2'd1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PORT_W-1:0] port;
        logic [PEER_W-1:0] peer_port;
        logic              rx_enable;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PORT_W-1:0]   local_port;
        logic [PEER_W-1:0]   stored_peer_port;
        logic                present;
        logic                hit;
    } t_rsp;

endpackage

### src/port_endpoint_table_allocator_core.sv
// Port endpoint table: one entry (in-use bit, receive-enable flag, 16-bit peer port) per
// local port, held in three single-port-write memories of PORT_COUNT entries. After reset
// the block sweeps the in-use map clear, one entry per clock, so it takes no request until
// the sweep is done; configuration writes are taken throughout. Requests are handled one
// at a time by a small sequencer around one shared slot-reduction unit (a multiply by the
// reciprocal of PORT_COUNT, then a multiply-subtract). Allocate-given, free, lookup and
// set-receive-enable pass the reduction unit (S_MUL, then S_SUB), with the addressed
// entry read from the memories as S_SUB ends; S_EXEC then decides and writes, and S_DONE
// loads the output register. An ephemeral allocate runs the reduction unit twice (range
// start and search start), then goes through S_STEP and S_CHECK for each candidate
// port, reading and checking the in-use map, until a free port is found or N candidates
// are tried, N at most port_last - port_first + 1 (1 for an inverted range). Undefined
// function codes return an all-zero result. The result sits in an output register, so
// the block goes back to idle once loaded and takes the next request in the next cycle.
module port_endpoint_table_allocator_core
    import peta_pkg::*;
#(
    parameter int PORT_COUNT = PORT_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_req                 i_in_req,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_rsp                 o_out_rsp,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PORT_W-1:0]    i_cfg_data
);

    localparam int SW      = $clog2(PORT_COUNT);
    localparam int Q_W     = PORT_W - $clog2(PORT_COUNT_MIN);
    localparam int RECIP_W = RECIP_SHIFT - $clog2(PORT_COUNT_MIN) + 1;
    localparam int PROD_W  = PORT_W + RECIP_W;
    localparam int TRY_W   = PORT_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PORT_COUNT) - 64'd1) / 64'(PORT_COUNT));
    localparam logic [SW-1:0] SLOT_LAST = SW'(PORT_COUNT - 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SUB   = 3'd3;
    localparam logic [2:0] S_STEP  = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_EXEC  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // table memories
    logic              mem_use  [PORT_COUNT];
    logic              mem_rx   [PORT_COUNT];
    logic [PEER_W-1:0] mem_peer [PORT_COUNT];

    logic [2:0]        r_state, n_state;
    logic [SW-1:0]     r_clr, n_clr;
    t_req              r_req, n_req;
    logic              r_pass, n_pass;
    logic [SW-1:0]     r_slot, n_slot;
    logic [SW-1:0]     r_first_slot, n_first_slot;
    logic [PORT_W-1:0] r_cand, n_cand;
    logic [TRY_W-1:0]  r_left, n_left;
    logic [PORT_W-1:0] r_first, r_last;
    logic [PORT_W-1:0] r_start, n_start;
    logic [Q_W-1:0]    r_q;
    t_rsp              r_res, n_res;
    t_rsp              r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic              r_use_q, r_rx_q;
    logic [PEER_W-1:0] r_peer_q;

    logic              w_we_use, w_wd_use, w_we_rx, w_wd_rx, w_we_peer;
    logic [SW-1:0]     w_waddr;
    logic [PORT_W-1:0] w_mul_a;
    logic [PROD_W-1:0] w_prod;
    logic [31:0]       w_rem;
    logic [SW-1:0]     w_slot_inc;
    logic [TRY_W-1:0]  w_trials;
    logic [TRY_W-1:0]  w_next;
    logic              w_wrap;
    logic              w_func_ok;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign o_cfg_ready = 1'b1;

    // Shared slot reduction: pass 0 reduces the addressed port (or port_first for an
    // ephemeral allocate), pass 1 reduces the search start.
    assign w_mul_a = r_pass ? r_start
                   : ((r_req.func == FN_ALLOC_EPH) ? r_first : r_req.port);
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(RECIP);
    assign w_rem   = 32'(w_mul_a) - 32'(r_q) * 32'(PORT_COUNT);

    // Walk the slot alongside the candidate port so each trial needs no reduction.
    assign w_slot_inc = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
    assign w_trials   = (r_first <= r_last)
                      ? ({1'b0, r_last} - {1'b0, r_first} + TRY_W'(1)) : TRY_W'(1);
    assign w_next     = {1'b0, r_cand} + TRY_W'(1);
    assign w_wrap     = (w_next < {1'b0, r_first}) || (w_next > {1'b0, r_last});

    assign w_func_ok = (i_in_req.func == FN_ALLOC_EPH) || (i_in_req.func == FN_ALLOC_FIX)
                    || (i_in_req.func == FN_FREE) || (i_in_req.func == FN_LOOKUP)
                    || (i_in_req.func == FN_SET_RX);

    assign w_waddr = (r_state == S_CLEAR) ? r_clr : r_slot;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_req        = r_req;
        n_pass       = r_pass;
        n_slot       = r_slot;
        n_first_slot = r_first_slot;
        n_cand       = r_cand;
        n_left       = r_left;
        n_start      = r_start;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        w_we_use     = 1'b0;
        w_wd_use     = 1'b0;
        w_we_rx      = 1'b0;
        w_wd_rx      = 1'b0;
        w_we_peer    = 1'b0;

        // drop the result once the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_we_use = 1'b1;
                n_clr    = r_clr + 1'b1;
                if (r_clr == SLOT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req  = i_in_req;
                    n_pass = 1'b0;
                    if (w_func_ok) begin
                        n_state = S_MUL;
                    end else begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_MUL: begin
                n_state = S_SUB;
            end
            S_SUB: begin
                if (r_req.func == FN_ALLOC_EPH) begin
                    if (!r_pass) begin
                        n_first_slot = w_rem[SW-1:0];
                        n_pass       = 1'b1;
                        n_state      = S_MUL;
                    end else begin
                        n_slot  = w_rem[SW-1:0];
                        n_cand  = r_start;
                        n_left  = w_trials;
                        n_state = S_STEP;
                    end
                end else begin
                    // read of the addressed entry lands for S_EXEC
                    n_slot  = w_rem[SW-1:0];
                    n_state = S_EXEC;
                end
            end
            S_STEP: begin
                if (w_wrap) begin
                    n_cand = r_first;
                    n_slot = r_first_slot;
                end else begin
                    n_cand = w_next[PORT_W-1:0];
                    n_slot = w_slot_inc;
                end
                n_left  = r_left - TRY_W'(1);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_res = '0;
                if (!r_use_q) begin
                    w_we_use         = 1'b1;
                    w_wd_use         = 1'b1;
                    w_we_rx          = 1'b1;
                    w_wd_rx          = 1'b1;
                    w_we_peer        = 1'b1;
                    n_start          = r_cand;
                    n_res.status     = ST_OK;
                    n_res.local_port = r_cand;
                    n_res.present    = 1'b1;
                    n_state          = S_DONE;
                end else if (r_left == '0) begin
                    n_res.status = ST_NO_FREE;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_EXEC: begin
                n_res            = '0;
                n_res.local_port = r_req.port;
                n_state          = S_DONE;
                unique case (r_req.func)
                    FN_ALLOC_FIX: begin
                        n_res.present = 1'b1;
                        if (r_use_q) begin
                            n_res.status = ST_IN_USE;
                        end else begin
                            w_we_use  = 1'b1;
                            w_wd_use  = 1'b1;
                            w_we_rx   = 1'b1;
                            w_wd_rx   = 1'b1;
                            w_we_peer = 1'b1;
                        end
                    end
                    FN_FREE: begin
                        if (r_use_q) begin
                            w_we_use = 1'b1;
                        end else begin
                            n_res.status = ST_ABSENT;
                        end
                    end
                    FN_LOOKUP: begin
                        if (r_use_q) begin
                            n_res.present          = 1'b1;
                            n_res.stored_peer_port = r_peer_q;
                            n_res.hit              = r_rx_q;
                        end else begin
                            n_res.status = ST_ABSENT;
                        end
                    end
                    FN_SET_RX: begin
                        if (r_use_q) begin
                            w_we_rx       = 1'b1;
                            w_wd_rx       = r_req.rx_enable;
                            n_res.present = 1'b1;
                        end else begin
                            n_res.status = ST_ABSENT;
                        end
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_first     <= PORT_FIRST_RST;
            r_last      <= PORT_LAST_RST;
            r_start     <= PORT_FIRST_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && (i_cfg_index == CFG_PORT_FIRST)) begin
                // writing port_first also reloads the search start
                r_first <= i_cfg_data;
                r_start <= i_cfg_data;
            end else begin
                r_start <= n_start;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_PORT_LAST)) begin
                r_last <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_pass       <= n_pass;
        r_slot       <= n_slot;
        r_first_slot <= n_first_slot;
        r_cand       <= n_cand;
        r_left       <= n_left;
        r_res        <= n_res;
        r_out        <= n_out;
        r_q          <= w_prod[RECIP_SHIFT +: Q_W];
    end

    // table memories: one write address, registered read at the next slot
    always_ff @(posedge i_clk) begin
        if (w_we_use) begin
            mem_use[w_waddr] <= w_wd_use;
        end
        if (w_we_rx) begin
            mem_rx[w_waddr] <= w_wd_rx;
        end
        if (w_we_peer) begin
            mem_peer[w_waddr] <= r_req.peer_port;
        end
        r_use_q  <= mem_use[n_slot];
        r_rx_q   <= mem_rx[n_slot];
        r_peer_q <= mem_peer[n_slot];
    end

    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // a hit only comes with a present entry and ok status
    a_hit_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.hit) |-> (o_out_rsp.present && (o_out_rsp.status == ST_OK)))
        else $error("hit without present entry");

    // a failed search reports no port
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_rsp.status == ST_NO_FREE))
            |-> ((o_out_rsp.local_port == '0) && !o_out_rsp.present && !o_out_rsp.hit))
        else $error("failed search reported a port");

    // every candidate checked lies in the range, or is port_first for an empty range
    a_cand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK)
            |-> (((r_cand >= r_first) && (r_cand <= r_last)) || (r_cand == r_first)))
        else $error("search candidate outside the ephemeral range");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import peta_pkg::*;

    localparam int TABLE_DEPTH = PORT_COUNT_DEF;
    // slowest request: two passes through the reduction unit plus a step and a check per candidate
    localparam int SEARCH_MAX_CYCLES = 6 + 2 * TABLE_DEPTH;
    // allowance per request for the sender's gaps and the receiver's stalls
    localparam int GAP_ALLOW   = 40;
    localparam int STALL_ALLOW = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = SEARCH_MAX_CYCLES + 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 o_in_stall;
    t_req                 in_req = '0;
    logic                 o_out_valid;
    logic                 out_stall = 1'b0;
    t_rsp                 o_out_rsp;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PORT_W-1:0]    cfg_data = '0;

    // shadow of the port table and the range registers
    bit                entry_used [TABLE_DEPTH];
    bit                entry_rx_en [TABLE_DEPTH];
    bit [PEER_W-1:0]   entry_peer [TABLE_DEPTH];
    bit [PORT_W-1:0]   range_first = PORT_FIRST_RST;
    bit [PORT_W-1:0]   range_last = PORT_LAST_RST;
    bit [PORT_W-1:0]   search_from = PORT_FIRST_RST;

    t_req              request_q[$];
    t_rsp              expected_rsps[$];
    t_rsp              rsp_want;
    int unsigned       requests_queued = 0;
    int unsigned       responses_checked = 0;
    int unsigned       mismatch_cnt = 0;

    int unsigned       send_idle_pct = 7;
    int unsigned       recv_idle_pct = 47;
    int unsigned       hold_left = 0;
    bit                hold_done = 1'b0;

    longint unsigned   worst_cycles = TABLE_DEPTH + 100;
    longint unsigned   cycle_cnt = 0;

    port_endpoint_table_allocator_core #(
        .PORT_COUNT (TABLE_DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Number of candidates the ephemeral search may try under the current range.
    // An inverted range still gets one trial, at range_first.
    function automatic int unsigned search_trials();
        return (range_first <= range_last) ? range_last - range_first + 1 : 1;
    endfunction

    // Apply one request to the shadow table and return the response it must produce.
    function automatic t_rsp port_table_step(t_req r);
        t_rsp              rsp;
        int unsigned       trials;
        int unsigned       cand;
        int unsigned       t;
        bit                found;
        int unsigned       slot;
        rsp = '0;
        slot = r.port % TABLE_DEPTH;
        case (r.func)
            FN_ALLOC_EPH: begin
                trials = search_trials();
                cand = search_from;
                found = 1'b0;
                // walk onward from the last port handed out, wrapping into the range
                for (t = 0; t < trials && !found; t++) begin
                    cand = cand + 1;
                    if (cand < range_first || cand > range_last)
                        cand = range_first;
                    if (!entry_used[cand % TABLE_DEPTH])
                        found = 1'b1;
                end
                if (found) begin
                    search_from = PORT_W'(cand);
                    entry_used[cand % TABLE_DEPTH] = 1'b1;
                    entry_rx_en[cand % TABLE_DEPTH] = 1'b1;
                    entry_peer[cand % TABLE_DEPTH] = r.peer_port;
                    rsp.local_port = PORT_W'(cand);
                    rsp.present = 1'b1;
                end else begin
                    rsp.status = ST_NO_FREE;
                end
            end
            FN_ALLOC_FIX: begin
                rsp.local_port = r.port;
                rsp.present = 1'b1;
                if (entry_used[slot]) begin
                    rsp.status = ST_IN_USE;
                end else begin
                    entry_used[slot] = 1'b1;
                    entry_rx_en[slot] = 1'b1;
                    entry_peer[slot] = r.peer_port;
                end
            end
            FN_FREE: begin
                rsp.local_port = r.port;
                if (entry_used[slot])
                    entry_used[slot] = 1'b0;
                else
                    rsp.status = ST_ABSENT;
            end
            FN_LOOKUP: begin
                rsp.local_port = r.port;
                if (entry_used[slot]) begin
                    rsp.present = 1'b1;
                    rsp.stored_peer_port = entry_peer[slot];
                    rsp.hit = entry_rx_en[slot];
                end else begin
                    rsp.status = ST_ABSENT;
                end
            end
            FN_SET_RX: begin
                rsp.local_port = r.port;
                if (entry_used[slot]) begin
                    entry_rx_en[slot] = r.rx_enable;
                    rsp.present = 1'b1;
                end else begin
                    rsp.status = ST_ABSENT;
                end
            end
            default: begin
                // undefined function codes leave the table alone and return all zeros
            end
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("response %0d: %s got %0h want %0h",
                                      responses_checked, name, got, want));
    endtask

    // Queue one request and widen the run budget by its worst-case cost.
    task automatic push_req(input logic [FUNC_W-1:0] func, input logic [PORT_W-1:0] port,
                            input logic [PEER_W-1:0] peer, input logic rx_en);
        t_req r;
        r.func = func;
        r.port = port;
        r.peer_port = peer;
        r.rx_enable = rx_en;
        request_q.push_back(r);
        requests_queued++;
        worst_cycles += GAP_ALLOW + STALL_ALLOW
                      + ((func == FN_ALLOC_EPH) ? 6 + 2 * search_trials() : 6);
    endtask

    // Favor ports around the start of the range so that frees, lookups and clashes
    // land on live entries; the rest spread over the whole port space.
    function automatic logic [PORT_W-1:0] pick_port();
        int unsigned span;
        span = (range_first <= range_last) ? range_last - range_first : 3;
        if (span > 47)
            span = 47;
        if ($urandom_range(99) < 70)
            return PORT_W'(range_first + $urandom_range(span));
        return PORT_W'($urandom);
    endfunction

    task automatic push_random(input int unsigned count);
        int unsigned          w;
        int unsigned          n;
        logic [FUNC_W-1:0]    f;
        for (n = 0; n < count; n++) begin
            w = $urandom_range(99);
            if (w < 30)
                f = FN_ALLOC_EPH;
            else if (w < 45)
                f = FN_ALLOC_FIX;
            else if (w < 65)
                f = FN_FREE;
            else if (w < 85)
                f = FN_LOOKUP;
            else if (w < 95)
                f = FN_SET_RX;
            else
                f = FUNC_W'($urandom_range(5, 7));
            push_req(f, pick_port(), PEER_W'($urandom), 1'($urandom));
        end
    endtask

    // Hold until every queued request has come back as a response.
    task automatic wait_drained();
        while (responses_checked != requests_queued)
            @(posedge clk);
    endtask

    // Write the range registers while the block is idle. Keep valid high across a
    // back-to-back pair and drop it once after the last write.
    task automatic program_range(input bit wr_first, input bit wr_last,
                                 input logic [PORT_W-1:0] first_val,
                                 input logic [PORT_W-1:0] last_val);
        wait_drained();
        if (wr_first) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_PORT_FIRST;
            cfg_data <= first_val;
            @(posedge clk);
            while (o_cfg_ready !== 1'b1)
                @(posedge clk);
            range_first = first_val;
            search_from = first_val;
        end
        if (wr_last) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_PORT_LAST;
            cfg_data <= last_val;
            @(posedge clk);
            while (o_cfg_ready !== 1'b1)
                @(posedge clk);
            range_last = last_val;
        end
        if (wr_first || wr_last)
            cfg_valid <= 1'b0;
    endtask

    // Request driver: predict on acceptance, then offer the next pending request
    // unless this cycle is an idle one. A stalled request is held unchanged.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall)
                expected_rsps.push_back(port_table_step(in_req));
            if (!in_valid || !o_in_stall) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_req <= request_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Response receiver: random stalls, plus one long hold-off once the no-idle stretch
    // has a backlog, so the block fills up and stalls the request side.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_done && send_idle_pct == 0 && recv_idle_pct == 0
                     && request_q.size() > 30) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Response monitor: compare each accepted response with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && o_out_valid === 1'b1 && out_stall == 1'b0) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                rsp_want = expected_rsps.pop_front();
                check_field("status", o_out_rsp.status, rsp_want.status);
                check_field("local_port", o_out_rsp.local_port, rsp_want.local_port);
                check_field("stored_peer_port", o_out_rsp.stored_peer_port,
                            rsp_want.stored_peer_port);
                check_field("present", o_out_rsp.present, rsp_want.present);
                check_field("hit", o_out_rsp.hit, rsp_want.hit);
                responses_checked++;
            end
        end
    end

    // Watchdog: the budget grows with every queued request, four times over.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 4 * worst_cycles + HOLD_CYCLES + TAIL_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned ph;
        int unsigned sel;
        int unsigned n;
        logic [PORT_W-1:0] lo;
        logic [PORT_W-1:0] hi;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset range 1..4095: absent lookup, ephemeral from the reset search start,
        // both ends of the port space, clash, receive-enable toggling, undefined codes.
        push_req(FN_LOOKUP, 12'd5, 16'h0000, 1'b0);
        push_req(FN_ALLOC_EPH, 12'd0, 16'hFFFF, 1'b0);
        push_req(FN_ALLOC_FIX, 12'hFFF, 16'h0000, 1'b0);
        push_req(FN_ALLOC_FIX, 12'hFFF, 16'h5555, 1'b1);
        push_req(FN_ALLOC_FIX, 12'd0, 16'h1234, 1'b0);
        push_req(FN_SET_RX, 12'd0, 16'h0000, 1'b0);
        push_req(FN_LOOKUP, 12'd0, 16'hFFFF, 1'b1);
        push_req(FN_SET_RX, 12'd0, 16'hFFFF, 1'b1);
        push_req(FN_LOOKUP, 12'd0, 16'h0000, 1'b0);
        push_req(FN_FREE, 12'hFFF, 16'h0000, 1'b0);
        push_req(FN_FREE, 12'hFFF, 16'h0000, 1'b0);
        push_req(FN_SET_RX, 12'd7, 16'h0000, 1'b1);
        push_req(3'd5, 12'hFFF, 16'hFFFF, 1'b1);
        push_req(3'd6, 12'hAAA, 16'h5A5A, 1'b0);
        push_req(3'd7, 12'd0, 16'h0000, 1'b1);
        push_random(40);

        // Range 0..7 with port 0 live: fill it up until the search reports no free port.
        program_range(1'b1, 1'b1, 12'd0, 12'd7);
        repeat (9) push_req(FN_ALLOC_EPH, PORT_W'($urandom), PEER_W'($urandom), 1'b0);
        push_random(40);

        // Inverted range: one trial at port_first only.
        program_range(1'b1, 1'b1, 12'hFFF, 12'd0);
        push_req(FN_ALLOC_EPH, 12'd0, 16'hBEEF, 1'b0);
        push_req(FN_ALLOC_EPH, 12'd0, 16'hCAFE, 1'b0);
        push_req(FN_LOOKUP, 12'hFFF, 16'h0000, 1'b0);
        push_random(20);

        // Whole port space.
        program_range(1'b1, 1'b1, 12'd0, 12'hFFF);
        push_random(40);

        // Single-port range.
        program_range(1'b1, 1'b1, 12'd2048, 12'd2048);
        push_req(FN_ALLOC_EPH, 12'd0, 16'h0001, 1'b0);
        push_req(FN_ALLOC_EPH, 12'd0, 16'h0002, 1'b0);
        push_random(20);

        // Random ranges, mostly narrow so the search wraps and runs dry often.
        // Sometimes write only one register so the search start may sit outside.
        for (ph = 0; ph < 14; ph++) begin
            wait_drained();
            if (ph == 4) begin
                send_idle_pct = 47;
                recv_idle_pct = 7;
            end else if (ph == 9) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sel = $urandom_range(9);
            if (sel == 0) begin
                lo = PORT_W'($urandom_range(1, 4095));
                hi = PORT_W'($urandom_range(0, lo - 1));
            end else if (sel == 1) begin
                lo = PORT_W'($urandom_range(0, 15));
                hi = 12'hFFF;
            end else begin
                lo = PORT_W'($urandom_range(4095));
                n = lo + $urandom_range(0, 39);
                hi = (n > 4095) ? 12'hFFF : PORT_W'(n);
            end
            sel = $urandom_range(3);
            program_range(sel != 0, sel != 1, lo, hi);
            push_random(55);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
